// File: hw/rtl/sorted_insertion_buffer_assert.svh
// Assertion macros used by the checker of the sorted insertion buffer.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef SORTED_INSERTION_BUFFER_ASSERT_SVH
`define SORTED_INSERTION_BUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SIB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sib_pkg.sv
// Shared types and constants of the sorted insertion buffer.
// Depends on nothing; used by the interfaces and all modules.
package sib_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_ELEMENT  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    insert;
    logic    rotate;
    logic    rd_start;
    logic    out_load;
    status_t out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic fill_one;
    logic rd_final;
  } sts_t;

endpackage

// File: hw/rtl/sib_if.sv
// Valid/ready channel interfaces of the sorted insertion buffer.
// Depends on sib_pkg for the field widths and the status type.
interface sib_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [sib_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sib_out_if;
  logic                                valid;
  logic                                ready;
  sib_pkg::status_t                    status;
  logic signed [sib_pkg::VALUE_W-1:0]  element;
  logic                                last;

  modport source (output valid, output status, output element, output last, input ready);
  modport sink   (input valid, input status, input element, input last, output ready);
endinterface

// File: hw/rtl/sib_datapath.sv
// Datapath of the sorted insertion buffer: compare-and-shift cell row,
// fill and readout counters, and the result register. Depends on sib_pkg.
module sib_datapath #(
  parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  sib_pkg::cmd_t                      cmd,
  output sib_pkg::sts_t                      sts,
  input  logic signed [sib_pkg::VALUE_W-1:0] in_value,
  output sib_pkg::status_t                   out_status,
  output logic signed [sib_pkg::VALUE_W-1:0] out_element,
  output logic                               out_last
);

  localparam int FW = $clog2(CAPACITY + 1);

  logic signed [sib_pkg::VALUE_W-1:0] cell_r   [CAPACITY];
  logic signed [sib_pkg::VALUE_W-1:0] cell_nxt [CAPACITY];
  logic [CAPACITY-1:0]                take;
  logic [FW-1:0]                      fill_r, fill_nxt;
  logic [FW-1:0]                      rd_left_r, rd_left_nxt;
  sib_pkg::status_t                   status_r;
  logic signed [sib_pkg::VALUE_W-1:0] element_r;
  logic                               last_r;

  // A cell takes a new value when it holds something not below the incoming
  // value, or lies beyond the filled part. The flags rise monotonically.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (FW'(i) < fill_r) begin
        take[i] = (cell_r[i] >= in_value);
      end else begin
        take[i] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
      if (cmd.insert) begin
        if (take[i]) begin
          if (i > 0 && take[(i > 0) ? i - 1 : 0]) begin
            cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
          end else begin
            cell_nxt[i] = in_value;
          end
        end
      end else if (cmd.rotate) begin
        // Rotate the filled part down by one so that cell 0 shows the next value.
        if (FW'(i) + FW'(1) == fill_r) begin
          cell_nxt[i] = cell_r[0];
        end else if (FW'(i) + FW'(1) < fill_r) begin
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    rd_left_nxt = rd_left_r;
    if (cmd.insert) begin
      fill_nxt = fill_r + FW'(1);
    end
    if (cmd.rd_start) begin
      rd_left_nxt = fill_r - FW'(1);
    end else if (cmd.rotate) begin
      rd_left_nxt = rd_left_r - FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
    if (!rst_n) begin
      fill_r    <= '0;
      rd_left_r <= '0;
    end else begin
      fill_r    <= fill_nxt;
      rd_left_r <= rd_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      if (cmd.out_status == sib_pkg::ST_ELEMENT) begin
        element_r <= cell_r[0];
        last_r    <= cmd.rd_start ? (fill_r == FW'(1)) : (rd_left_r == FW'(1));
      end else begin
        element_r <= '0;
        last_r    <= 1'b1;
      end
    end
  end

  assign sts.full     = (fill_r == FW'(CAPACITY));
  assign sts.empty    = (fill_r == '0);
  assign sts.fill_one = (fill_r == FW'(1));
  assign sts.rd_final = (rd_left_r == FW'(1));

  assign out_status  = status_r;
  assign out_element = element_r;
  assign out_last    = last_r;

endmodule

// File: hw/rtl/sib_ctrl.sv
// Controller of the sorted insertion buffer: request acceptance, readout
// sequencing and result valid. Depends on sib_pkg.
module sib_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output sib_pkg::cmd_t cmd,
  input  sib_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_status = sib_pkg::ST_INSERTED;
    case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        if (in_valid && slot_free) begin
          cmd.out_load = 1'b1;
          if (in_action == sib_pkg::ACT_INSERT) begin
            cmd.insert     = !sts.full;
            cmd.out_status = sts.full ? sib_pkg::ST_FULL : sib_pkg::ST_INSERTED;
          end else if (sts.empty) begin
            cmd.out_status = sib_pkg::ST_EMPTY;
          end else begin
            cmd.out_status = sib_pkg::ST_ELEMENT;
            cmd.rd_start   = 1'b1;
            cmd.rotate     = 1'b1;
            if (!sts.fill_one) begin
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (slot_free) begin
          cmd.out_load   = 1'b1;
          cmd.rotate     = 1'b1;
          cmd.out_status = sib_pkg::ST_ELEMENT;
          if (sts.rd_final) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: hw/rtl/sorted_insertion_buffer.sv
// Sorted insertion buffer: top level joining controller and datapath.
// Depends on sib_pkg, sib_if, sib_ctrl and sib_datapath.
//
// The buffer holds up to CAPACITY signed 32-bit values in ascending order in
// a row of compare-and-shift cells. On an insert request every cell compares
// itself with the new value in parallel, and the cells from the insertion
// point upwards shift up by one, so inserts can follow each other in
// consecutive cycles while the sink takes each result. An insert into a full
// buffer is dropped and answered with a full status. A readout request of n
// stored values produces n results, one per cycle while the sink keeps
// taking them; the row rotates its filled part by one place per result and
// always presents the next value from cell 0, so after a complete readout
// the order is restored. No new request is taken until the last readout
// result has been loaded. An empty buffer answers a readout with a single
// empty status. Every result passes through a single output register, so the
// next request is accepted in the same cycle as the previous result is
// taken. After reset the buffer is empty; no clearing pass is needed.
module sorted_insertion_buffer #(
  parameter int CAPACITY = sib_pkg::CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sib_in_if.sink    in_ch,
  sib_out_if.source out_ch
);

  sib_pkg::cmd_t cmd;
  sib_pkg::sts_t sts;

  // The controller decides what each cycle does; the datapath only follows.
  sib_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The cell row, the fill count and the result register live here.
  sib_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_value    (in_ch.value),
    .out_status  (out_ch.status),
    .out_element (out_ch.element),
    .out_last    (out_ch.last)
  );

endmodule

// File: hw/rtl/sib_checker.sv
// Port-level checker of the sorted insertion buffer, bound to the top level.
// Depends on sib_pkg and sorted_insertion_buffer_assert.svh.
`include "sorted_insertion_buffer_assert.svh"

module sib_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input sib_pkg::status_t                   out_status,
  input logic signed [sib_pkg::VALUE_W-1:0] out_element,
  input logic                               out_last
);

  // A stalled result keeps its contents.
  `SIB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_element) && $stable(out_last), "result changed while stalled")

  // Status-only results carry a zero element.
  `SIB_ASSERT_IMP(a_status_zero, clk, rst_n, out_valid && out_status != sib_pkg::ST_ELEMENT, out_element == '0, "non-element result with nonzero element")

  // Status-only results are always the single and final result of a request.
  `SIB_ASSERT_IMP(a_status_last, clk, rst_n, out_valid && out_status != sib_pkg::ST_ELEMENT, out_last, "non-element result without last")

  // While a readout is still running, no new request is taken.
  `SIB_ASSERT_IMP(a_read_busy, clk, rst_n, out_valid && out_status == sib_pkg::ST_ELEMENT && !out_last, !in_ready, "request taken during readout")

endmodule

bind sorted_insertion_buffer sib_checker u_sib_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_element (out_ch.element),
  .out_last    (out_ch.last)
);
